// ===== rtl/point_to_pixel_projection_macros.svh =====
// Assertion helpers for the RTL checker file.
`ifndef POINT_TO_PIXEL_PROJECTION_MACROS_SVH
`define POINT_TO_PIXEL_PROJECTION_MACROS_SVH

// Checked on every clock edge outside reset.
`define PPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PPP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ppp_pkg.sv =====
package ppp_pkg;

  localparam int PIXEL_BITS_DEF = 12;
  localparam int CAM_W          = 24;
  localparam int COEF_W         = 16;
  localparam int FOCAL_W        = 20;
  localparam int PP_W           = 16;
  localparam int NUM_W          = 46;   // focal*cam + pp*z, signed
  localparam int NMAG_W         = 45;   // magnitude of the numerator
  localparam int DEN_W          = 28;   // |z| * 16
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0,
    REG_ROW1,
    REG_ROW2,
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_PP,
    REG_WIDTH,
    REG_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][CFG_DATA_W-1:0] row;
    logic [FOCAL_W-1:0]         fx;
    logic [FOCAL_W-1:0]         fy;
    logic [2*PP_W-1:0]          pp;
  } cfg_t;

  // x in the lowest bits
  typedef struct packed {
    logic [CAM_W-1:0] z;
    logic [CAM_W-1:0] y;
    logic [CAM_W-1:0] x;
  } cam_t;

endpackage

// ===== rtl/ppp_front.sv =====
module ppp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  ppp_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  ppp_pkg::cam_t in_point,
  output logic          q_wr,
  input  logic          q_full,
  output ppp_pkg::cam_t q_data
);
  import ppp_pkg::*;

  localparam int PROD_W = CAM_W + COEF_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam logic signed [ACC_W-1:0] CAM_MAX = ACC_W'((1 <<< (CAM_W-1)) - 1);
  localparam logic signed [ACC_W-1:0] CAM_MIN = -ACC_W'(1 <<< (CAM_W-1));

  logic [2:0] v_r;
  logic       adv;
  logic signed [CAM_W-1:0]  pt [3];
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic signed [ACC_W-1:0]  acc_r [3];
  logic signed [ACC_W-1:0]  sh [3];
  logic signed [CAM_W-1:0]  cam_nxt [3];
  logic signed [CAM_W-1:0]  cam_r [3];

  assign adv      = !(v_r[2] && q_full);
  assign in_ready = adv;
  assign q_wr     = v_r[2] && !q_full;
  assign q_data   = '{z: cam_r[2], y: cam_r[1], x: cam_r[0]};

  assign pt[0] = in_point.x;
  assign pt[1] = in_point.y;
  assign pt[2] = in_point.z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= pt[j] * $signed(cfg.row[i][COEF_W*j +: COEF_W]);
        end
        // translation lines up with the rotation products at 2^13, plus rounding
        acc_r[i] <= ACC_W'(prod_r[i][0]) + ACC_W'(prod_r[i][1]) + ACC_W'(prod_r[i][2])
                  + (ACC_W'($signed(cfg.row[i][CFG_DATA_W-1 -: COEF_W])) <<< 13)
                  + ACC_W'(4096);
        cam_r[i] <= cam_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = acc_r[i] >>> 13;
      if (sh[i] > CAM_MAX) begin
        cam_nxt[i] = CAM_MAX[CAM_W-1:0];
      end else if (sh[i] < CAM_MIN) begin
        cam_nxt[i] = CAM_MIN[CAM_W-1:0];
      end else begin
        cam_nxt[i] = sh[i][CAM_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/ppp_queue.sv =====
module ppp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  ppp_pkg::cam_t wdata,
  output logic          full,
  input  logic          rd,
  output logic          nonempty,
  output ppp_pkg::cam_t rdata
);
  import ppp_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  cam_t          mem [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_wr, do_rd;

  assign full     = cnt_r == (AW+1)'(QUEUE_DEPTH);
  assign nonempty = cnt_r != '0;
  assign do_wr    = wr && !full;
  assign do_rd    = rd && nonempty;
  assign rdata    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + AW'(1);
      end
      if (do_rd) begin
        rp_r <= rp_r + AW'(1);
      end
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

// ===== rtl/ppp_back.sv =====
module ppp_back #(
  parameter int PIXEL_BITS = ppp_pkg::PIXEL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppp_pkg::cfg_t         cfg,
  input  logic [PIXEL_BITS-1:0] image_width,
  input  logic [PIXEL_BITS-1:0] image_height,
  input  logic                  q_valid,
  output logic                  q_rd,
  input  ppp_pkg::cam_t         q_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_BITS-1:0] pixel_col,
  output logic [PIXEL_BITS-1:0] pixel_row,
  output logic                  on_image,
  output ppp_pkg::cam_t         cam_out
);
  import ppp_pkg::*;

  localparam int PB    = PIXEL_BITS;
  localparam int PPV_W = (PB + 3 > PP_W) ? PB + 3 : PP_W;
  localparam int PF_W  = FOCAL_W + 1 + CAM_W;
  localparam int PM_W  = PPV_W + 1 + CAM_W;
  localparam int CW    = (NMAG_W > DEN_W + PB) ? NMAG_W : DEN_W + PB;

  typedef struct packed {
    cam_t       cam;
    logic       zero;
    logic [1:0] neg;
    logic [1:0] ovf;
  } side_t;

  logic adv;
  logic v1_r, v2_r, v3_r, out_v_r;
  logic [PB:0] vd_r;

  logic [PPV_W-1:0] pp_sel [2];
  logic [FOCAL_W-1:0] fsel [2];
  logic signed [CAM_W-1:0] csel [2];

  logic signed [PF_W-1:0]  pf1_r [2];
  logic signed [PM_W-1:0]  pm1_r [2];
  cam_t                    cam1_r, cam2_r, cam3_r;
  logic signed [NUM_W-1:0] num2_r [2];
  logic [NMAG_W-1:0]       nmag3_r [2];
  logic [1:0]              neg3_r;
  logic [DEN_W-1:0]        dmag3_r;
  logic [CAM_W-1:0]        zabs;

  logic [CW-1:0]    rem_r [2][PB+1];
  logic [PB-1:0]    quo_r [2][PB+1];
  logic [DEN_W-1:0] d_r [PB+1];
  side_t            side_r [PB+1];

  logic [PB-1:0] col_r, row_r;
  logic          on_r;
  cam_t          camo_r;
  logic [1:0]    ok;
  logic [PB-1:0] size_sel [2];

  assign adv       = !out_v_r || out_ready;
  assign q_rd      = adv && q_valid;
  assign out_valid = out_v_r;
  assign pixel_col = col_r;
  assign pixel_row = row_r;
  assign on_image  = on_r;
  assign cam_out   = camo_r;

  // zero principal coordinate selects the image center
  assign pp_sel[0] = (cfg.pp[PP_W-1:0] == '0) ? (PPV_W'(image_width >> 1) << 4)
                                              : PPV_W'(cfg.pp[PP_W-1:0]);
  assign pp_sel[1] = (cfg.pp[2*PP_W-1:PP_W] == '0) ? (PPV_W'(image_height >> 1) << 4)
                                                   : PPV_W'(cfg.pp[2*PP_W-1:PP_W]);
  assign fsel[0] = cfg.fx;
  assign fsel[1] = cfg.fy;
  assign csel[0] = q_data.x;
  assign csel[1] = q_data.y;
  assign size_sel[0] = image_width;
  assign size_sel[1] = image_height;

  assign zabs = cam2_r.z[CAM_W-1] ? -cam2_r.z : cam2_r.z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      vd_r    <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v1_r    <= q_valid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      vd_r    <= {vd_r[PB-1:0], v3_r};
      out_v_r <= vd_r[PB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 2; a++) begin
        pf1_r[a]   <= $signed({1'b0, fsel[a]}) * csel[a];
        pm1_r[a]   <= $signed({1'b0, pp_sel[a]}) * $signed(q_data.z);
        num2_r[a]  <= NUM_W'(pf1_r[a]) + NUM_W'(pm1_r[a]);
        nmag3_r[a] <= num2_r[a][NUM_W-1] ? NMAG_W'(-num2_r[a]) : NMAG_W'(num2_r[a]);
        neg3_r[a]  <= num2_r[a][NUM_W-1] ^ cam2_r.z[CAM_W-1];
        // quotient must fit in PB bits, else the point is off the image
        rem_r[a][0] <= CW'(nmag3_r[a]);
        quo_r[a][0] <= '0;
      end
      cam1_r  <= q_data;
      cam2_r  <= cam1_r;
      cam3_r  <= cam2_r;
      dmag3_r <= DEN_W'({zabs, 4'b0000});

      d_r[0]         <= dmag3_r;
      side_r[0].cam  <= cam3_r;
      side_r[0].zero <= cam3_r.z == '0;
      side_r[0].neg  <= neg3_r;
      for (int a = 0; a < 2; a++) begin
        side_r[0].ovf[a] <= CW'(nmag3_r[a]) >= (CW'(dmag3_r) << PB);
      end

      // restoring division, one quotient bit per stage
      for (int j = 0; j < PB; j++) begin
        d_r[j+1]    <= d_r[j];
        side_r[j+1] <= side_r[j];
        for (int a = 0; a < 2; a++) begin
          if (rem_r[a][j] >= (CW'(d_r[j]) << (PB-1-j))) begin
            rem_r[a][j+1] <= rem_r[a][j] - (CW'(d_r[j]) << (PB-1-j));
            quo_r[a][j+1] <= quo_r[a][j] | (PB'(1) << (PB-1-j));
          end else begin
            rem_r[a][j+1] <= rem_r[a][j];
            quo_r[a][j+1] <= quo_r[a][j];
          end
        end
      end

      on_r   <= !side_r[PB].zero && (&ok);
      col_r  <= (!side_r[PB].zero && (&ok)) ? quo_r[0][PB] : '0;
      row_r  <= (!side_r[PB].zero && (&ok)) ? quo_r[1][PB] : '0;
      camo_r <= side_r[PB].cam;
    end
  end

  // a negative quotient is on the image only when it truncates to zero
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      ok[a] = !side_r[PB].ovf[a] && !(side_r[PB].neg[a] && quo_r[a][PB] != '0)
              && (quo_r[a][PB] < size_sel[a]);
    end
  end

endmodule

// ===== rtl/point_to_pixel_projection.sv =====
// From input transfer to result valid: 3 transform stages, the point queue,
//   3 projection stages, the range check, one divider stage per pixel bit
//   and the output register; the divider is fully pipelined.
// Throughput: one point and one divider quotient per cycle unless the output stalls.
// Reset (rst_n low, synchronous): pipelines and queue empty, registers at defaults.
module point_to_pixel_projection #(
  parameter int PIXEL_BITS = ppp_pkg::PIXEL_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [3*ppp_pkg::CAM_W-1:0]          in_tdata,   // point_x, point_y, point_z
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pixel_col, pixel_row, cam_x, cam_y, cam_z, zero fill
  output logic [((2*PIXEL_BITS+3*ppp_pkg::CAM_W+7)/8)*8-1:0] out_tdata,
  output logic                                 out_tuser,  // on_image
  input  logic                                 cfg_we,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import ppp_pkg::*;

  localparam int OUT_W = ((2*PIXEL_BITS + 3*CAM_W + 7) / 8) * 8;

  cfg_t                  cfg_r;
  logic [PIXEL_BITS-1:0] width_r, height_r;

  logic          q_wr, q_full, q_rd, q_nonempty;
  cam_t          q_wdata, q_rdata;
  logic [PIXEL_BITS-1:0] col, row;
  logic          on_img;
  cam_t          cam;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= '0;
      width_r  <= PIXEL_BITS'(RESET_WIDTH);
      height_r <= PIXEL_BITS'(RESET_HEIGHT);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ROW0:    cfg_r.row[0] <= cfg_wdata;
        REG_ROW1:    cfg_r.row[1] <= cfg_wdata;
        REG_ROW2:    cfg_r.row[2] <= cfg_wdata;
        REG_FOCAL_X: cfg_r.fx     <= cfg_wdata[FOCAL_W-1:0];
        REG_FOCAL_Y: cfg_r.fy     <= cfg_wdata[FOCAL_W-1:0];
        REG_PP:      cfg_r.pp     <= cfg_wdata[2*PP_W-1:0];
        REG_WIDTH:   width_r      <= cfg_wdata[PIXEL_BITS-1:0];
        REG_HEIGHT:  height_r     <= cfg_wdata[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  ppp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_point (cam_t'(in_tdata)),
    .q_wr     (q_wr),
    .q_full   (q_full),
    .q_data   (q_wdata)
  );

  ppp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr),
    .wdata    (q_wdata),
    .full     (q_full),
    .rd       (q_rd),
    .nonempty (q_nonempty),
    .rdata    (q_rdata)
  );

  ppp_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .image_width  (width_r),
    .image_height (height_r),
    .q_valid      (q_nonempty),
    .q_rd         (q_rd),
    .q_data       (q_rdata),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .pixel_col    (col),
    .pixel_row    (row),
    .on_image     (on_img),
    .cam_out      (cam)
  );

  assign out_tdata = OUT_W'({cam, row, col});
  assign out_tuser = on_img;

endmodule

// ===== rtl/ppp_checker.sv =====
`include "point_to_pixel_projection_macros.svh"

module ppp_checker #(
  parameter int PIXEL_BITS = ppp_pkg::PIXEL_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic out_tvalid,
  input logic out_tready,
  input logic [((2*PIXEL_BITS+3*ppp_pkg::CAM_W+7)/8)*8-1:0] out_tdata,
  input logic out_tuser
);
  import ppp_pkg::*;

  localparam int ZLO = 2*PIXEL_BITS + 2*CAM_W;

  `PPP_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid, "result valid right after reset")
  `PPP_ASSERT(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `PPP_ASSERT(a_off_zero, out_tvalid && !out_tuser |-> out_tdata[2*PIXEL_BITS-1:0] == '0, "off-image pixel not zero")
  `PPP_ASSERT(a_zero_depth, out_tvalid && out_tdata[ZLO +: CAM_W] == '0 |-> !out_tuser, "zero depth flagged on image")

endmodule

bind point_to_pixel_projection ppp_checker #(.PIXEL_BITS(PIXEL_BITS)) u_ppp_checker (.*);

// ===== tb/sv/ppp_checker.sv =====
module ppp_tb_checker #(
  parameter int PIXEL_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  input  logic                                   in_tready,
  input  logic [71:0]                            in_tdata,
  input  logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic [((2*PIXEL_BITS+72+7)/8)*8-1:0]   out_tdata,
  input  logic                                   out_tuser,
  input  logic                                   cfg_we,
  input  logic [2:0]                             cfg_index,
  input  logic [63:0]                            cfg_wdata,
  output int                                     fail_count,
  output int                                     pending
);
  import ppp_pkg::*;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] col;
    logic [PIXEL_BITS-1:0] row;
    logic                  on_img;
    logic [23:0]           cx;
    logic [23:0]           cy;
    logic [23:0]           cz;
  } pixel_res_t;

  logic [63:0]           rows [3];
  logic [19:0]           fx, fy;
  logic [31:0]           pp;
  logic [PIXEL_BITS-1:0] img_w, img_h;
  pixel_res_t            pixel_q [$];

  function automatic longint cam_coord(logic [63:0] r, longint px, longint py, longint pz);
    longint acc;
    acc = px * longint'($signed(r[15:0])) + py * longint'($signed(r[31:16]))
        + pz * longint'($signed(r[47:32])) + longint'($signed(r[63:48])) * 8192 + 4096;
    acc = acc >>> 13;
    if (acc > 8388607) acc = 8388607;
    if (acc < -8388608) acc = -8388608;
    return acc;
  endfunction

  function automatic longint pixel_coord(longint f, longint c, longint z, longint ppf,
                                         longint sz);
    longint p;
    p = ppf;
    if (p == 0) p = (sz / 2) * 16;
    return (f * c + p * z) / (z * 16);  // SV division truncates toward zero
  endfunction

  function automatic pixel_res_t project_point(logic [71:0] d);
    pixel_res_t r;
    longint px, py, pz, cx, cy, cz, u, v;
    px = $signed(d[23:0]);
    py = $signed(d[47:24]);
    pz = $signed(d[71:48]);
    cx = cam_coord(rows[0], px, py, pz);
    cy = cam_coord(rows[1], px, py, pz);
    cz = cam_coord(rows[2], px, py, pz);
    r = '0;
    if (cz != 0) begin
      u = pixel_coord(fx, cx, cz, pp[15:0], img_w);
      v = pixel_coord(fy, cy, cz, pp[31:16], img_h);
      if (u >= 0 && u < img_w && v >= 0 && v < img_h) begin
        r.col = u[PIXEL_BITS-1:0];
        r.row = v[PIXEL_BITS-1:0];
        r.on_img = 1'b1;
      end
    end
    r.cx = cx[23:0];
    r.cy = cy[23:0];
    r.cz = cz[23:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_res_t e, a;
    if (!rst_n) begin
      rows[0] <= '0; rows[1] <= '0; rows[2] <= '0;
      fx <= '0; fy <= '0; pp <= '0;
      img_w <= PIXEL_BITS'(640); img_h <= PIXEL_BITS'(480);
      fail_count <= 0;
      pending <= 0;
      pixel_q.delete();
    end else begin
      if (in_tvalid && in_tready) pixel_q.insert(pixel_q.size(), project_point(in_tdata));
      if (out_tvalid && out_tready) begin
        a.col = out_tdata[PIXEL_BITS-1:0];
        a.row = out_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
        a.cx = out_tdata[2*PIXEL_BITS +: 24];
        a.cy = out_tdata[2*PIXEL_BITS+24 +: 24];
        a.cz = out_tdata[2*PIXEL_BITS+48 +: 24];
        a.on_img = out_tuser;
        if (pixel_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer %p", a);
          fail_count <= fail_count + 1;
        end else begin
          e = pixel_q.pop_front();
          if (e !== a) begin
            if (fail_count < 10) $display("mismatch: expected %p actual %p", e, a);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= pixel_q.size();
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_ROW0:    rows[0] <= cfg_wdata;
          REG_ROW1:    rows[1] <= cfg_wdata;
          REG_ROW2:    rows[2] <= cfg_wdata;
          REG_FOCAL_X: fx <= cfg_wdata[19:0];
          REG_FOCAL_Y: fy <= cfg_wdata[19:0];
          REG_PP:      pp <= cfg_wdata[31:0];
          REG_WIDTH:   img_w <= cfg_wdata[PIXEL_BITS-1:0];
          REG_HEIGHT:  img_h <= cfg_wdata[PIXEL_BITS-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
module tb;
  import ppp_pkg::*;

  localparam int PB = 12;
  localparam int OW = ((2*PB+72+7)/8)*8;

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_tvalid = 0;
  logic          in_tready;
  logic [71:0]   in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 0;
  logic [OW-1:0] out_tdata;
  logic          out_tuser;
  logic          cfg_we = 0;
  logic [2:0]    cfg_index = '0;
  logic [63:0]   cfg_wdata = '0;
  int            fail_count, pending;
  bit            hold_rx = 0;
  bit            stim_done = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  point_to_pixel_projection #(.PIXEL_BITS(PB)) DUT (.*);

  ppp_tb_checker #(.PIXEL_BITS(PB)) chk (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // receiver: random stalls, long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_tready <= 0;
        for (n = 0; n < 200; n++) @(negedge clk);
        hold_rx = 0;
      end
      out_tready <= ($urandom_range(0, 3) != 0) || stim_done;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain_pipe();
    int n;
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    for (n = 0; n < 30; n++) @(negedge clk);
  endtask

  task automatic send_point(logic [71:0] d, bit gaps);
    int g;
    in_tvalid <= 1; in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic logic [23:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 60000)) - 30000);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [63:0] rot_row(int k);
    logic [63:0] r;
    r = '0;
    r[16*k +: 16] = 16'h2000;  // 1.0 in Q2.13
    r[63:48] = 16'($urandom_range(0, 4095));
    return r;
  endfunction

  task automatic setup_camera(int mode);
    case (mode)
      0: begin  // identity-ish, centered
        write_reg(REG_ROW0, rot_row(0));
        write_reg(REG_ROW1, rot_row(1));
        write_reg(REG_ROW2, {16'd5120, 16'h2000, 32'h0});
        write_reg(REG_FOCAL_X, 64'(20'd8000));
        write_reg(REG_FOCAL_Y, 64'(20'd8000));
        write_reg(REG_PP, 64'(32'h0));
        write_reg(REG_WIDTH, 64'(640));
        write_reg(REG_HEIGHT, 64'(480));
      end
      1: begin  // extremes
        write_reg(REG_ROW0, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_ROW1, 64'h8000_8000_8000_8000);
        write_reg(REG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_FOCAL_X, 64'(20'hFFFFF));
        write_reg(REG_FOCAL_Y, 64'(20'h0));
        write_reg(REG_PP, 64'(32'h0000_FFFF));
        write_reg(REG_WIDTH, 64'(4095));
        write_reg(REG_HEIGHT, 64'(1));
      end
      2: begin  // fully random
        write_reg(REG_ROW0, {$urandom(), $urandom()});
        write_reg(REG_ROW1, {$urandom(), $urandom()});
        write_reg(REG_ROW2, {$urandom(), $urandom()});
        write_reg(REG_FOCAL_X, 64'($urandom()));
        write_reg(REG_FOCAL_Y, 64'($urandom()));
        write_reg(REG_PP, 64'($urandom()));
        write_reg(REG_WIDTH, 64'($urandom()));
        write_reg(REG_HEIGHT, 64'($urandom()));
      end
      default: begin  // plausible camera, one principal field zero
        write_reg(REG_ROW0, {16'($urandom_range(0, 2047)), 16'd0, 16'($urandom_range(0, 400)),
                             16'h2000 - 16'($urandom_range(0, 200))});
        write_reg(REG_ROW1, {16'($urandom_range(0, 2047)), 16'($urandom_range(0, 400)),
                             16'h2000, 16'd0});
        write_reg(REG_ROW2, {16'($urandom_range(1024, 8192)), 16'h2000, 16'd0,
                             16'($urandom_range(0, 300))});
        write_reg(REG_FOCAL_X, 64'($urandom_range(2000, 20000)));
        write_reg(REG_FOCAL_Y, 64'($urandom_range(2000, 20000)));
        write_reg(REG_PP, 64'($urandom_range(0, 1) ? {16'd0, 16'($urandom_range(1, 65535))}
                                                   : {16'($urandom_range(1, 65535)), 16'd0}));
        write_reg(REG_WIDTH, 64'($urandom_range(1, 2000)));
        write_reg(REG_HEIGHT, 64'($urandom_range(1, 2000)));
      end
    endcase
  endtask

  initial begin
    int i, ph;
    logic [23:0] z;
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // reset config: all zero matrix, so depth zero everywhere
    send_point({24'h7FFFFF, 24'h800000, 24'h000001}, 1'b0);
    drain_pipe();
    setup_camera(0);
    send_point('0, 1'b0);
    send_point({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, 1'b0);
    send_point({24'h800000, 24'h800000, 24'h800000}, 1'b0);
    send_point({24'hFFEC00, 24'h0, 24'h0}, 1'b0);    // lands at zero depth
    send_point({24'h002800, 24'h000400, 24'h000800}, 1'b0);
    send_point({24'hFFD000, 24'hFFF000, 24'hFFF800}, 1'b0);
    send_point({24'h100000, 24'h000000, 24'h000000}, 1'b0);
    drain_pipe();
    setup_camera(1);
    for (i = 0; i < 6; i++) send_point({rnd_coord(), rnd_coord(), rnd_coord()}, 1'b0);
    drain_pipe();
    for (ph = 0; ph < 9; ph++) begin
      setup_camera(ph == 2 ? 1 : (ph % 4 == 1 ? 2 : (ph % 4 == 0 ? 0 : 3)));
      if (ph == 3) hold_rx = 1;
      for (i = 0; i < 50; i++) begin
        z = $urandom_range(0, 4) == 0 ? rnd_coord() : 24'($urandom_range(512, 60000));
        send_point({z, 24'($signed($urandom_range(0, 40000)) - 20000),
                    24'($signed($urandom_range(0, 40000)) - 20000)}, ph != 3);
        if ($urandom_range(0, 4) == 0)
          send_point({rnd_coord(), rnd_coord(), rnd_coord()}, ph != 3);
      end
      in_tvalid <= 0;
      drain_pipe();
    end
    stim_done = 1;
    drain_pipe();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end
endmodule
